// ===== src/imufs_pkg.sv =====
// ----------------------------------------------------------------------------
// imufs_pkg
// Shared types, constants and the arithmetic sequencer program of the IMU
// frame synchronizer and rotation block.
// ----------------------------------------------------------------------------
package imufs_pkg;

	localparam int unsigned FRAME_LEN = 11;
	localparam logic [7:0] HDR_BYTE  = 8'h55;
	localparam logic [7:0] TYPE_GYRO = 8'h52;
	localparam logic [7:0] TYPE_QUAT = 8'h59;

	// Gyro scale 2000*pi/(180*32768) in Q32.
	localparam logic signed [41:0] GYRO_K = 42'sd4575276;
	localparam logic signed [63:0] SAT_MAX = 64'sd4194303;
	localparam logic signed [63:0] SAT_MIN = -64'sd4194304;

	localparam logic [4:0] PC_GYRO  = 5'd0;
	localparam logic [4:0] PC_QUAT  = 5'd3;
	localparam logic [4:0] PC_GEND  = 5'd2;
	localparam logic [4:0] PC_ROT   = 5'd9;
	localparam logic [4:0] PC_LAST  = 5'd23;

	localparam logic [1:0] REG_MOUNT_W = 2'd0;
	localparam logic [1:0] REG_MOUNT_X = 2'd1;
	localparam logic [1:0] REG_MOUNT_Y = 2'd2;
	localparam logic [1:0] REG_MOUNT_Z = 2'd3;

	typedef enum logic {KIND_GYRO = 1'b0, KIND_QUAT = 1'b1} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [3:0][15:0]       word;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} mount_t;

	typedef enum logic [2:0] {
		A_W0, A_W1, A_W2, A_W3, A_MW, A_MX, A_MY, A_MZ
	} a_sel_t;

	typedef enum logic [3:0] {
		B_K, B_W0, B_W1, B_W2, B_W3, B_V0, B_V1, B_V2, B_T0, B_T1, B_T2
	} b_sel_t;

	typedef enum logic [2:0] {I_ZERO, I_HALF, I_V0, I_V1, I_V2} init_t;

	typedef enum logic [3:0] {
		D_V0, D_V1, D_V2, D_T0, D_T1, D_T2, D_R0, D_R1, D_R2
	} dst_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic   neg;
		logic   first;
		logic   last;
		init_t  init;
		dst_t   dst;
	} uop_t;

	function automatic uop_t mk(input a_sel_t a, input b_sel_t b, input logic n,
			input logic f, input logic l, input init_t i, input dst_t d);
		uop_t u;
		u.a_sel = a;
		u.b_sel = b;
		u.neg   = n;
		u.first = f;
		u.last  = l;
		u.init  = i;
		u.dst   = d;
		return u;
	endfunction

	// Program: gyro scaling, gravity from quaternion, then the shared
	// mounting rotation t = 2*cross(m,v), r = v<<28 + mw*t + cross(m,t).
	function automatic uop_t uop_rom(input logic [4:0] pc);
		uop_t u;
		case (pc)
			5'd0:  u = mk(A_W0, B_K,  1'b0, 1'b1, 1'b1, I_ZERO, D_V0);
			5'd1:  u = mk(A_W1, B_K,  1'b0, 1'b1, 1'b1, I_ZERO, D_V1);
			5'd2:  u = mk(A_W2, B_K,  1'b0, 1'b1, 1'b1, I_ZERO, D_V2);
			5'd3:  u = mk(A_W0, B_W2, 1'b0, 1'b1, 1'b0, I_ZERO, D_V0);
			5'd4:  u = mk(A_W1, B_W3, 1'b1, 1'b0, 1'b1, I_ZERO, D_V0);
			5'd5:  u = mk(A_W0, B_W1, 1'b1, 1'b1, 1'b0, I_ZERO, D_V1);
			5'd6:  u = mk(A_W2, B_W3, 1'b1, 1'b0, 1'b1, I_ZERO, D_V1);
			5'd7:  u = mk(A_W0, B_W0, 1'b1, 1'b1, 1'b0, I_HALF, D_V2);
			5'd8:  u = mk(A_W3, B_W3, 1'b1, 1'b0, 1'b1, I_HALF, D_V2);
			5'd9:  u = mk(A_MY, B_V2, 1'b0, 1'b1, 1'b0, I_ZERO, D_T0);
			5'd10: u = mk(A_MZ, B_V1, 1'b1, 1'b0, 1'b1, I_ZERO, D_T0);
			5'd11: u = mk(A_MZ, B_V0, 1'b0, 1'b1, 1'b0, I_ZERO, D_T1);
			5'd12: u = mk(A_MX, B_V2, 1'b1, 1'b0, 1'b1, I_ZERO, D_T1);
			5'd13: u = mk(A_MX, B_V1, 1'b0, 1'b1, 1'b0, I_ZERO, D_T2);
			5'd14: u = mk(A_MY, B_V0, 1'b1, 1'b0, 1'b1, I_ZERO, D_T2);
			5'd15: u = mk(A_MW, B_T0, 1'b0, 1'b1, 1'b0, I_V0,   D_R0);
			5'd16: u = mk(A_MY, B_T2, 1'b0, 1'b0, 1'b0, I_V0,   D_R0);
			5'd17: u = mk(A_MZ, B_T1, 1'b1, 1'b0, 1'b1, I_V0,   D_R0);
			5'd18: u = mk(A_MW, B_T1, 1'b0, 1'b1, 1'b0, I_V1,   D_R1);
			5'd19: u = mk(A_MZ, B_T0, 1'b0, 1'b0, 1'b0, I_V1,   D_R1);
			5'd20: u = mk(A_MX, B_T2, 1'b1, 1'b0, 1'b1, I_V1,   D_R1);
			5'd21: u = mk(A_MW, B_T2, 1'b0, 1'b1, 1'b0, I_V2,   D_R2);
			5'd22: u = mk(A_MX, B_T1, 1'b0, 1'b0, 1'b0, I_V2,   D_R2);
			5'd23: u = mk(A_MY, B_T0, 1'b1, 1'b0, 1'b1, I_V2,   D_R2);
			default: u = mk(A_W0, B_K, 1'b0, 1'b1, 1'b1, I_ZERO, D_V0);
		endcase
		return u;
	endfunction

endpackage

// ===== src/imufs_if.sv =====
// ----------------------------------------------------------------------------
// imufs_byte_if / imufs_res_if
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface imufs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufs_res_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [22:0] vec_x;
	logic signed [22:0] vec_y;
	logic signed [22:0] vec_z;
	logic signed [15:0] orient_w;
	logic signed [15:0] orient_x;
	logic signed [15:0] orient_y;
	logic signed [15:0] orient_z;

	modport source (output valid, output kind, output vec_x, output vec_y, output vec_z,
		output orient_w, output orient_x, output orient_y, output orient_z, input ready);
	modport sink (input valid, input kind, input vec_x, input vec_y, input vec_z,
		input orient_w, input orient_x, input orient_y, input orient_z, output ready);
endinterface

// ===== src/imufs_front.sv =====
// ----------------------------------------------------------------------------
// imufs_front
// Byte framer: header hunt, checksum check, window slide on mismatch.
// ----------------------------------------------------------------------------
module imufs_front
	import imufs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       push,
	output frame_t     push_frame
);

	logic [7:0] win_q [FRAME_LEN];
	logic [3:0] fill_q;

	logic       acc;
	logic [7:0] sum8;
	logic [7:0] ext [FRAME_LEN];
	logic [4:0] nxt;
	logic       full_now;
	logic       sum_ok;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign full_now = (fill_q == 4'(FRAME_LEN - 1));

	always_comb begin
		sum8 = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++) begin
			sum8 = sum8 + win_q[i];
		end
		for (int i = 0; i < FRAME_LEN - 1; i++) begin
			ext[i] = win_q[i];
		end
		ext[FRAME_LEN - 1] = in_byte;
		// First header after the dropped first byte, or past the end.
		nxt = 5'(FRAME_LEN);
		for (int j = FRAME_LEN - 1; j >= 1; j--) begin
			if (ext[j] == HDR_BYTE) begin
				nxt = 5'(j);
			end
		end
	end

	assign sum_ok = (sum8 == in_byte);

	always_comb begin
		push_frame.kind = (win_q[1] == TYPE_QUAT) ? KIND_QUAT : KIND_GYRO;
		for (int k = 0; k < 4; k++) begin
			push_frame.word[k] = {win_q[3 + 2 * k], win_q[2 + 2 * k]};
		end
		push = acc && full_now && sum_ok &&
			((win_q[1] == TYPE_GYRO) || (win_q[1] == TYPE_QUAT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc) begin
			if (fill_q == 4'd0) begin
				if (in_byte == HDR_BYTE) begin
					fill_q <= 4'd1;
				end
			end else if (!full_now) begin
				fill_q <= fill_q + 4'd1;
			end else if (sum_ok) begin
				fill_q <= 4'd0;
			end else begin
				fill_q <= 4'(5'(FRAME_LEN) - nxt);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (fill_q == 4'd0) begin
				win_q[0] <= in_byte;
			end else if (!full_now) begin
				win_q[fill_q] <= in_byte;
			end else if (!sum_ok) begin
				for (int j = 0; j < FRAME_LEN - 1; j++) begin
					if (5'(j) + nxt < 5'(FRAME_LEN)) begin
						win_q[j] <= ext[4'(5'(j) + nxt)];
					end
				end
			end
		end
	end

endmodule

// ===== src/imufs_fifo.sv =====
// ----------------------------------------------------------------------------
// imufs_fifo
// Two-entry frame queue between the framer and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module imufs_fifo
	import imufs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t din,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output frame_t dout
);

	frame_t     mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

// ===== src/imufs_back.sv =====
// ----------------------------------------------------------------------------
// imufs_back
// Multiply-accumulate sequencer: gyro scaling, gravity and mounting rotation.
// ----------------------------------------------------------------------------
module imufs_back
	import imufs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_empty,
	output logic   pop,
	input  frame_t q_frame,
	input  mount_t mount,
	imufs_res_if.source out_ch
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [4:0]          pc_q;
	logic                wait_q;
	frame_t              frame_q;
	logic signed [23:0]  v_q [3];
	logic signed [41:0]  t_q [3];
	logic signed [22:0]  r_q [3];

	logic signed [57:0]  p_s1;
	uop_t                ctl_s1;
	logic                vld_s1;
	logic signed [63:0]  acc_q;
	dst_t                dst_s2;
	logic                fin_s2;

	uop_t                uop;
	logic signed [15:0]  a_op;
	logic signed [41:0]  b_op;
	logic signed [63:0]  init_val;
	logic signed [63:0]  p_ext;
	logic signed [63:0]  rnd;
	logic signed [63:0]  rr;

	assign uop = uop_rom(pc_q);
	assign pop = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		case (uop.a_sel)
			A_W0:    a_op = signed'(frame_q.word[0]);
			A_W1:    a_op = signed'(frame_q.word[1]);
			A_W2:    a_op = signed'(frame_q.word[2]);
			A_W3:    a_op = signed'(frame_q.word[3]);
			A_MW:    a_op = mount.w;
			A_MX:    a_op = mount.x;
			A_MY:    a_op = mount.y;
			A_MZ:    a_op = mount.z;
			default: a_op = '0;
		endcase
		case (uop.b_sel)
			B_K:     b_op = GYRO_K;
			B_W0:    b_op = 42'(signed'(frame_q.word[0]));
			B_W1:    b_op = 42'(signed'(frame_q.word[1]));
			B_W2:    b_op = 42'(signed'(frame_q.word[2]));
			B_W3:    b_op = 42'(signed'(frame_q.word[3]));
			B_V0:    b_op = 42'(v_q[0]);
			B_V1:    b_op = 42'(v_q[1]);
			B_V2:    b_op = 42'(v_q[2]);
			B_T0:    b_op = t_q[0];
			B_T1:    b_op = t_q[1];
			B_T2:    b_op = t_q[2];
			default: b_op = '0;
		endcase
	end

	always_comb begin
		case (ctl_s1.init)
			I_HALF:  init_val = 64'sd1 <<< 29;
			I_V0:    init_val = 64'(v_q[0]) <<< 28;
			I_V1:    init_val = 64'(v_q[1]) <<< 28;
			I_V2:    init_val = 64'(v_q[2]) <<< 28;
			default: init_val = '0;
		endcase
		p_ext = 64'(p_s1);
	end

	// Round half up per destination and kind, R saturated; T is doubled.
	always_comb begin
		rnd = '0;
		rr  = '0;
		case (dst_s2)
			D_V0, D_V1, D_V2: begin
				if (frame_q.kind == KIND_GYRO) begin
					rnd = (acc_q + (64'sd1 <<< 15)) >>> 16;
				end else begin
					rnd = (acc_q + (64'sd1 <<< 12)) >>> 13;
				end
			end
			D_R0, D_R1, D_R2: begin
				if (frame_q.kind == KIND_GYRO) begin
					rr = (acc_q + (64'sd1 <<< 27)) >>> 28;
				end else begin
					rr = (acc_q + (64'sd1 <<< 29)) >>> 30;
				end
				if (rr > SAT_MAX) begin
					rnd = SAT_MAX;
				end else if (rr < SAT_MIN) begin
					rnd = SAT_MIN;
				end else begin
					rnd = rr;
				end
			end
			default: rnd = acc_q <<< 1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			wait_q  <= 1'b0;
			vld_s1  <= 1'b0;
			fin_s2  <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			fin_s2 <= vld_s1 && ctl_s1.last;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						pc_q    <= (q_frame.kind == KIND_QUAT) ? PC_QUAT : PC_GYRO;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					vld_s1 <= 1'b1;
					if (uop.last) begin
						wait_q  <= 1'b1;
						state_q <= ST_WAIT;
					end else begin
						pc_q <= pc_q + 5'd1;
					end
				end
				ST_WAIT: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else if (pc_q == PC_LAST) begin
						state_q <= ST_OUT;
					end else begin
						pc_q    <= (pc_q == PC_GEND) ? PC_ROT : pc_q + 5'd1;
						state_q <= ST_RUN;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= q_frame;
		end
		p_s1   <= 58'(a_op * b_op);
		ctl_s1 <= uop;
		if (vld_s1) begin
			acc_q  <= (ctl_s1.first ? init_val : acc_q) + (ctl_s1.neg ? -p_ext : p_ext);
			dst_s2 <= ctl_s1.dst;
		end
		if (fin_s2) begin
			case (dst_s2)
				D_V0:    v_q[0] <= 24'(rnd);
				D_V1:    v_q[1] <= 24'(rnd);
				D_V2:    v_q[2] <= 24'(rnd);
				D_T0:    t_q[0] <= 42'(rnd);
				D_T1:    t_q[1] <= 42'(rnd);
				D_T2:    t_q[2] <= 42'(rnd);
				D_R0:    r_q[0] <= 23'(rnd);
				D_R1:    r_q[1] <= 23'(rnd);
				D_R2:    r_q[2] <= 23'(rnd);
				default: ;
			endcase
		end
	end

	always_comb begin
		out_ch.valid = (state_q == ST_OUT);
		out_ch.kind  = frame_q.kind;
		out_ch.vec_x = r_q[0];
		out_ch.vec_y = r_q[1];
		out_ch.vec_z = r_q[2];
		if (frame_q.kind == KIND_QUAT) begin
			out_ch.orient_w = signed'(frame_q.word[0]);
			out_ch.orient_x = signed'(frame_q.word[1]);
			out_ch.orient_y = signed'(frame_q.word[2]);
			out_ch.orient_z = signed'(frame_q.word[3]);
		end else begin
			out_ch.orient_w = '0;
			out_ch.orient_x = '0;
			out_ch.orient_y = '0;
			out_ch.orient_z = '0;
		end
	end

endmodule

// ===== src/imu_frame_sync_and_rotate_core.sv =====
// ----------------------------------------------------------------------------
// imu_frame_sync_and_rotate_core
// Serial IMU frame synchronizer with quaternion mounting rotation.
// ----------------------------------------------------------------------------
// Usage: received sensor bytes enter on in_ch, one byte per transfer. The
// framer hunts for the 0x55 header, gathers 11-byte frames and checks the
// sum byte; on a mismatch it slides to the next header in the window.
// The framer takes one byte per cycle as long as the two-entry frame queue
// has room, so bytes are never held up while a frame is being computed
// unless two complete frames are already waiting.
// Valid gyro (0x52) and quaternion (0x59) frames go to the arithmetic
// sequencer, which runs them through one 16x42 multiplier and a 64-bit
// accumulator: a gyro frame takes 18 multiply steps, a quaternion frame 21,
// plus an accumulate and a write-back step after each of the nine groups.
// The result stays on out_ch until the receiver accepts the transfer; while
// it waits the framer keeps taking bytes and the queue absorbs two frames.
// Reset clears the window fill count, the queue and the sequencer, and
// loads the mounting quaternion with identity (w = 16384 in Q2.14).
// Mounting registers are written through cfg_we/cfg_index/cfg_wdata.
// ----------------------------------------------------------------------------
module imu_frame_sync_and_rotate_core
	import imufs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	imufs_byte_if.sink  in_ch,
	imufs_res_if.source out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	mount_t mount_q;
	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	frame_t push_frame;
	frame_t q_frame;

	// Mounting quaternion registers, Q2.14, identity after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q.w <= 16'sd16384;
			mount_q.x <= '0;
			mount_q.y <= '0;
			mount_q.z <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOUNT_W: mount_q.w <= signed'(cfg_wdata);
				REG_MOUNT_X: mount_q.x <= signed'(cfg_wdata);
				REG_MOUNT_Y: mount_q.y <= signed'(cfg_wdata);
				REG_MOUNT_Z: mount_q.z <= signed'(cfg_wdata);
				default:     ;
			endcase
		end
	end

	// The framer validates frames and pushes the useful ones.
	imufs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_byte    (in_ch.rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_frame (push_frame)
	);

	// The queue decouples byte intake from the arithmetic.
	imufs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_frame),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.dout   (q_frame)
	);

	// The sequencer computes one frame at a time and holds its result.
	imufs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.pop     (pop),
		.q_frame (q_frame),
		.mount   (mount_q),
		.out_ch  (out_ch)
	);

endmodule

// ===== tb/imufs_tb_if.sv =====
// ----------------------------------------------------------------------------
// imufs testbench channels
// The byte and result channels come from the RTL interface file; this file
// holds the small result record shared by the testbench top level.
// ----------------------------------------------------------------------------
package imufs_tb_pkg;

	typedef struct packed {
		logic               kind;
		logic signed [22:0] vec_x;
		logic signed [22:0] vec_y;
		logic signed [22:0] vec_z;
		logic signed [15:0] orient_w;
		logic signed [15:0] orient_x;
		logic signed [15:0] orient_y;
		logic signed [15:0] orient_z;
	} imu_result_t;

endpackage

// ===== tb/imu_frame_sync_and_rotate_core_tb.sv =====
// ----------------------------------------------------------------------------
// imu_frame_sync_and_rotate_core_tb
// Self-checking bench for the IMU frame synchronizer. Bytes are sent over the
// byte channel with random gaps; a behavioral copy of the framer and of the
// fixed-point rotation predicts every result, and results taken from the
// result channel under random back-pressure are compared field by field.
// ----------------------------------------------------------------------------
module imu_frame_sync_and_rotate_core_tb;
	import imufs_pkg::*;
	import imufs_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_MOUNT_W;
	logic [15:0] cfg_wdata = '0;

	imufs_byte_if in_ch();
	imufs_res_if out_ch();

	imu_frame_sync_and_rotate_core uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Predictor state: the mounting quaternion and the byte window.
	logic signed [15:0] mnt_w = 16'sd16384, mnt_x = '0, mnt_y = '0, mnt_z = '0;
	logic [7:0] window [11];
	int fill = 0;

	imu_result_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int results_seen = 0;
	int frames_sent = 0;
	bit no_idle = 1'b0;

	// Round half up by s bits (arithmetic shift after adding half).
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [22:0] sat23(longint v);
		if (v > 64'sd4194303) return 23'sd4194303;
		if (v < -64'sd4194304) return -23'sd4194304;
		return v[22:0];
	endfunction

	// Rotation by the mounting quaternion, Q16 in, Q44 out.
	function automatic void mount_rotate(input longint v[3], output longint r[3]);
		longint mw, mx, my, mz, t0, t1, t2;
		mw = mnt_w; mx = mnt_x; my = mnt_y; mz = mnt_z;
		t0 = 2 * (my * v[2] - mz * v[1]);
		t1 = 2 * (mz * v[0] - mx * v[2]);
		t2 = 2 * (mx * v[1] - my * v[0]);
		r[0] = (v[0] <<< 28) + mw * t0 + (my * t2 - mz * t1);
		r[1] = (v[1] <<< 28) + mw * t1 + (mz * t0 - mx * t2);
		r[2] = (v[2] <<< 28) + mw * t2 + (mx * t1 - my * t0);
	endfunction

	function automatic longint frame_word(int i);
		logic signed [15:0] w;
		w = {window[i + 1], window[i]};
		return longint'(w);
	endfunction

	// Decode a complete, checksum-good window into its result, if any.
	function automatic void decode_frame();
		imu_result_t res;
		longint v[3], r[3], qw, qx, qy, qz;
		res = '0;
		if (window[1] == TYPE_GYRO) begin
			for (int i = 0; i < 3; i++)
				v[i] = round_shift(frame_word(2 + 2 * i) * 64'sd4575276, 16);
			mount_rotate(v, r);
			res.kind = KIND_GYRO;
			res.vec_x = sat23(round_shift(r[0], 28));
			res.vec_y = sat23(round_shift(r[1], 28));
			res.vec_z = sat23(round_shift(r[2], 28));
			expected_results.push_back(res);
		end else if (window[1] == TYPE_QUAT) begin
			qw = frame_word(2); qx = frame_word(4); qy = frame_word(6); qz = frame_word(8);
			v[0] = round_shift(2 * (qw * qy - qx * qz), 14);
			v[1] = round_shift(-2 * (qw * qx + qy * qz), 14);
			v[2] = round_shift((longint'(1) <<< 30) - 2 * qw * qw - 2 * qz * qz, 14);
			mount_rotate(v, r);
			res.kind = KIND_QUAT;
			res.vec_x = sat23(round_shift(r[0], 30));
			res.vec_y = sat23(round_shift(r[1], 30));
			res.vec_z = sat23(round_shift(r[2], 30));
			res.orient_w = qw[15:0]; res.orient_x = qx[15:0];
			res.orient_y = qy[15:0]; res.orient_z = qz[15:0];
			expected_results.push_back(res);
		end
	endfunction

	// Framer: hunt for the header, gather eleven bytes, check the sum byte and
	// slide to the next header on a mismatch.
	function automatic void predict_byte(logic [7:0] b);
		logic [7:0] sum;
		int nxt;
		if (fill == 0) begin
			if (b == HDR_BYTE) begin
				window[0] = b;
				fill = 1;
			end
			return;
		end
		window[fill] = b;
		fill++;
		if (fill < 11) return;
		sum = '0;
		for (int i = 0; i < 10; i++) sum += window[i];
		if (sum == window[10]) begin
			decode_frame();
			fill = 0;
			return;
		end
		nxt = 1;
		while (nxt < 11 && window[nxt] != HDR_BYTE) nxt++;
		fill = 11 - nxt;
		for (int i = 0; i < fill; i++) window[i] = window[i + nxt];
	endfunction

	// Watchdog and result checking, all on the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL imu_frame_sync_and_rotate_core");
			$finish;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin : check
				imu_result_t e;
				e = expected_results.pop_front();
				if (out_ch.kind !== e.kind) begin
					$error("kind: expected %0d got %0d", e.kind, out_ch.kind); errors++; end
				if (out_ch.vec_x !== e.vec_x) begin
					$error("vec_x: expected %0d got %0d", e.vec_x, out_ch.vec_x); errors++; end
				if (out_ch.vec_y !== e.vec_y) begin
					$error("vec_y: expected %0d got %0d", e.vec_y, out_ch.vec_y); errors++; end
				if (out_ch.vec_z !== e.vec_z) begin
					$error("vec_z: expected %0d got %0d", e.vec_z, out_ch.vec_z); errors++; end
				if (out_ch.orient_w !== e.orient_w) begin
					$error("orient_w: expected %0d got %0d", e.orient_w, out_ch.orient_w);
					errors++;
				end
				if (out_ch.orient_x !== e.orient_x) begin
					$error("orient_x: expected %0d got %0d", e.orient_x, out_ch.orient_x);
					errors++;
				end
				if (out_ch.orient_y !== e.orient_y) begin
					$error("orient_y: expected %0d got %0d", e.orient_y, out_ch.orient_y);
					errors++;
				end
				if (out_ch.orient_z !== e.orient_z) begin
					$error("orient_z: expected %0d got %0d", e.orient_z, out_ch.orient_z);
					errors++;
				end
			end
		end
	end

	// The receiver stalls about a quarter of the time, except while no_idle is set.
	initial out_ch.ready = 1'b0;
	always @(posedge clk)
		out_ch.ready <= no_idle || ($urandom_range(99) >= 24);

	// One byte transfer: random idle gap first, then hold valid until accepted.
	task automatic send_byte(logic [7:0] b);
		while (!no_idle && $urandom_range(99) < 24) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_byte(b);
	endtask

	// Build a frame with a correct sum byte; optionally corrupt the sum.
	task automatic send_frame(logic [7:0] ftype, logic [15:0] w0, logic [15:0] w1,
			logic [15:0] w2, logic [15:0] w3, bit bad_sum);
		logic [7:0] f [11];
		logic [7:0] sum;
		f = '{HDR_BYTE, ftype, w0[7:0], w0[15:8], w1[7:0], w1[15:8],
			w2[7:0], w2[15:8], w3[7:0], w3[15:8], 8'h00};
		sum = '0;
		for (int i = 0; i < 10; i++) sum += f[i];
		f[10] = bad_sum ? sum ^ 8'(1 + $urandom_range(254)) : sum;
		for (int i = 0; i < 11; i++) send_byte(f[i]);
		frames_sent++;
	endtask

	// Stop sending, wait until every predicted result has been taken, then idle
	// for the DRAIN_CYCLES stretch before going on.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller drops the write enable after the last one.
	task automatic write_mount(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_MOUNT_W: mnt_w = val;
			REG_MOUNT_X: mnt_x = val;
			REG_MOUNT_Y: mnt_y = val;
			default:     mnt_z = val;
		endcase
	endtask

	task automatic write_all(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		write_mount(REG_MOUNT_W, w);
		write_mount(REG_MOUNT_X, x);
		write_mount(REG_MOUNT_Y, y);
		write_mount(REG_MOUNT_Z, z);
		cfg_we <= 1'b0;
	endtask

	// Directed rows. A row with check set carries its expected vector, typed in
	// by hand for the identity mounting right after reset.
	typedef struct {
		logic [7:0]  ftype;
		logic [15:0] w0, w1, w2, w3;
		bit          bad_sum;
		bit          check;
		logic signed [22:0] ex, ey, ez;
	} frame_row_t;

	frame_row_t directed[] = '{
		// All-zero gyro frame gives a zero rate.
		'{TYPE_GYRO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 0, 0, 0},
		// Identity orientation: gravity straight down, -1.0 in Q2.14.
		'{TYPE_QUAT, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 0, 0, -23'sd16382},
		// Zero quaternion: gravity becomes +1.0.
		'{TYPE_QUAT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 0, 0, 23'sd16384},
		'{TYPE_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 0, 0, 0},
		'{TYPE_GYRO, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 1'b0, 1'b0, 0, 0, 0},
		'{TYPE_QUAT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 0, 0, 0},
		'{TYPE_QUAT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 0, 0, 0},
		'{TYPE_QUAT, 16'h5A82, 16'h0000, 16'h5A82, 16'h0000, 1'b0, 1'b0, 0, 0, 0},
		// Unknown type, then a bad sum byte; neither gives a result.
		'{8'h51,     16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0, 1'b0, 0, 0, 0},
		'{TYPE_GYRO, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1, 1'b0, 0, 0, 0},
		// Payload full of header bytes exercises the slide after a bad sum.
		'{TYPE_QUAT, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 1'b1, 1'b0, 0, 0, 0},
		'{TYPE_GYRO, 16'h00FF, 16'hFF00, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 0, 0, 0}
	};

	// Random content with the extremes weighted in.
	function automatic logic [15:0] rand_word();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'(HDR_BYTE * 257);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		frame_row_t row;
		imu_result_t hand;
		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise before the first header is ignored.
		send_byte(8'h00);
		send_byte(8'hFF);
		foreach (directed[i]) begin
			row = directed[i];
			send_frame(row.ftype, row.w0, row.w1, row.w2, row.w3, row.bad_sum);
			if (row.check && expected_results.size() != 0) begin
				hand = expected_results[$];
				if (hand.vec_x !== row.ex || hand.vec_y !== row.ey || hand.vec_z !== row.ez) begin
					$error("directed row %0d: vec expected %0d %0d %0d predicted %0d %0d %0d",
						i, row.ex, row.ey, row.ez, hand.vec_x, hand.vec_y, hand.vec_z);
					errors++;
				end
			end
		end
		// The sender holds off until the whole backlog has come out.
		drain();

		// Random phases, each with its own mounting: identity first, then the two extremes,
		// a quarter turn about z, random values and identity written once more.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
				2: write_all(16'h8000, 16'h8000, 16'h8000, 16'h8000);
				3: write_all(16'h2D41, 16'h0000, 16'h0000, 16'h2D41);
				4: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				5: write_all(16'h4000, 16'h0000, 16'h0000, 16'h0000);
				default: ;
			endcase
			no_idle = (phase == 2);
			repeat (11) begin
				case ($urandom_range(9))
					0: send_byte(8'($urandom));
					1: send_frame(8'($urandom), rand_word(), rand_word(), rand_word(),
						rand_word(), 1'b0);
					2: send_frame($urandom_range(1) ? TYPE_GYRO : TYPE_QUAT, rand_word(),
						rand_word(), rand_word(), rand_word(), 1'b1);
					default: send_frame($urandom_range(1) ? TYPE_GYRO : TYPE_QUAT,
						rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
				endcase
			end
			no_idle = 1'b0;
			drain();
		end

		$display("Sent %0d frames plus noise over six mounting settings; %0d results checked.",
			frames_sent, results_seen);
		if (errors == 0)
			$display("PASS imu_frame_sync_and_rotate_core");
		else
			$display("FAIL imu_frame_sync_and_rotate_core");
		$finish;
	end

endmodule

// ===== sim.f =====
src/imufs_pkg.sv
src/imufs_if.sv
src/imufs_front.sv
src/imufs_fifo.sv
src/imufs_back.sv
src/imu_frame_sync_and_rotate_core.sv
tb/imufs_tb_if.sv
tb/imu_frame_sync_and_rotate_core_tb.sv
